/* rtl/core/chained_hash_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Shorthand for clocked implications, reset masked.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Types, sizes and helpers shared by the hash table controller and datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int BUCKETS = 256;
  localparam int NODES   = 512;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int IB_W    = $clog2(BUCKETS + 1);
  localparam int NIDX_W  = $clog2(NODES);
  localparam int NODE_W  = $clog2(NODES + 1);
  localparam logic [NODE_W-1:0] NIL = NODE_W'(NODES);
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam logic [1:0] REQ_PUT  = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_RST  = 2'd2;
  localparam logic [1:0] REQ_STEP = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  typedef enum logic [2:0] {
    RES_NONE, RES_FULL, RES_HIT, RES_STEP, RES_END
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_HWT, S_NRD, S_NCK, S_STW, S_SCAN, S_SCW, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic head_rd;
    logic head_src_iter;
    logic cur_from_head;
    logic cur_from_next;
    logic node_rd;
    logic node_src_iter;
    logic wr_val;
    logic insert;
    logic iter_clr;
    logic ib_inc;
    logic iter_from_next;
    logic iter_from_head;
    logic iter_nil;
    logic push;
    res_t res;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       cur_nil;
    logic       key_eq;
    logic       nn_nil;
    logic       pool_full;
    logic       iter_nil;
    logic       ib_end;
    logic       ib_vld;
    logic       out_free;
  } ctl_stat_t;

  // low bucket bits of key * HASH_MULT only depend on the low key bits
  function automatic logic [BKT_W-1:0] hash_bucket(input logic [31:0] k);
    logic [2*BKT_W-1:0] p;
    p = k[BKT_W-1:0] * HASH_MULT[BKT_W-1:0];
    return p[BKT_W-1:0];
  endfunction

endpackage

/* rtl/core/cht_ctrl.sv */
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: chain walk, insert, iterator scan and result push.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cht_pkg::ctl_stat_t stat,
  output cht_pkg::ctl_cmd_t  cmd
);
  import cht_pkg::*;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_NONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.req)
          REQ_PUT, REQ_GET: begin
            cmd.head_rd = 1'b1;
            state_nxt   = S_HWT;
          end
          REQ_RST: begin
            cmd.iter_clr = 1'b1;
            res_nxt      = RES_NONE;
            state_nxt    = S_SCAN;
          end
          default: begin
            if (stat.iter_nil) begin
              res_nxt   = RES_END;
              state_nxt = S_OUT;
            end else begin
              cmd.node_rd       = 1'b1;
              cmd.node_src_iter = 1'b1;
              state_nxt         = S_STW;
            end
          end
        endcase
      end
      S_HWT: begin
        cmd.cur_from_head = 1'b1;
        state_nxt         = S_NRD;
      end
      S_NRD: begin
        if (stat.cur_nil) begin
          state_nxt = S_OUT;
          if (stat.req == REQ_GET) begin
            res_nxt = RES_NONE;
          end else if (stat.pool_full) begin
            res_nxt = RES_FULL;
          end else begin
            cmd.insert = 1'b1;
            res_nxt    = RES_NONE;
          end
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_NCK;
        end
      end
      S_NCK: begin
        if (stat.key_eq) begin
          state_nxt = S_OUT;
          if (stat.req == REQ_GET) begin
            res_nxt = RES_HIT;
          end else begin
            cmd.wr_val = 1'b1;
            res_nxt    = RES_NONE;
          end
        end else begin
          cmd.cur_from_next = 1'b1;
          state_nxt         = S_NRD;
        end
      end
      S_STW: begin
        res_nxt            = RES_STEP;
        cmd.iter_from_next = 1'b1;
        if (stat.nn_nil) begin
          cmd.ib_inc = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        // one bucket per cycle until a live head or the end
        if (stat.ib_end) begin
          cmd.iter_nil = 1'b1;
          state_nxt    = S_OUT;
        end else if (stat.ib_vld) begin
          cmd.head_rd       = 1'b1;
          cmd.head_src_iter = 1'b1;
          state_nxt         = S_SCW;
        end else begin
          cmd.ib_inc = 1'b1;
        end
      end
      S_SCW: begin
        cmd.iter_from_head = 1'b1;
        state_nxt          = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/cht_dpath.sv */
// ----------------------------------------------------------------------------
// cht_dpath
// Bucket heads, node pool, iterator registers and the output register.
// ----------------------------------------------------------------------------
module cht_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [2:0]        out_tuser,
  input  cht_pkg::ctl_cmd_t  cmd,
  output cht_pkg::ctl_stat_t stat
);
  import cht_pkg::*;

  logic [NIDX_W-1:0] head_mem [BUCKETS];
  logic [31:0]       key_mem  [NODES];
  logic [31:0]       val_mem  [NODES];
  logic [NODE_W-1:0] next_mem [NODES];

  logic [BUCKETS-1:0] bvld_r;
  logic [1:0]         req_r;
  logic [31:0]        key_r, val_r;
  logic [BKT_W-1:0]   bucket_r;
  logic [NODE_W-1:0]  cur_r, head_r, used_r, iter_r;
  logic [IB_W-1:0]    ib_r;
  logic [NIDX_W-1:0]  head_q;
  logic               head_vld_q;
  logic [31:0]        nk_q, nv_q;
  logic [NODE_W-1:0]  nn_q;

  logic               out_vld_r;
  logic [31:0]        okey_r, oval_r;
  logic               ohit_r;
  logic [1:0]         ost_r;

  logic [BKT_W-1:0]   head_addr;
  logic [NODE_W-1:0]  node_sel;

  assign head_addr = cmd.head_src_iter ? ib_r[BKT_W-1:0] : bucket_r;
  assign node_sel  = cmd.node_src_iter ? iter_r : cur_r;

  // bucket head memory; valid bits stand in for the reset clear
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      head_mem[bucket_r] <= used_r[NIDX_W-1:0];
    end
    if (cmd.head_rd) begin
      head_q     <= head_mem[head_addr];
      head_vld_q <= bvld_r[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_mem[used_r[NIDX_W-1:0]]  <= key_r;
      next_mem[used_r[NIDX_W-1:0]] <= head_r;
    end
    if (cmd.insert) begin
      val_mem[used_r[NIDX_W-1:0]] <= val_r;
    end else if (cmd.wr_val) begin
      val_mem[cur_r[NIDX_W-1:0]] <= val_r;
    end
    if (cmd.node_rd) begin
      nk_q <= key_mem[node_sel[NIDX_W-1:0]];
      nv_q <= val_mem[node_sel[NIDX_W-1:0]];
      nn_q <= next_mem[node_sel[NIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_tuser;
      key_r    <= in_tdata[31:0];
      val_r    <= in_tdata[63:32];
      bucket_r <= hash_bucket(in_tdata[31:0]);
    end
    if (cmd.cur_from_head) begin
      cur_r  <= head_vld_q ? {1'b0, head_q} : NIL;
      head_r <= head_vld_q ? {1'b0, head_q} : NIL;
    end else if (cmd.cur_from_next) begin
      cur_r <= nn_q;
    end
    if (cmd.push) begin
      okey_r <= (cmd.res == RES_STEP) ? nk_q : 32'd0;
      oval_r <= (cmd.res == RES_STEP || cmd.res == RES_HIT) ? nv_q : 32'd0;
      ohit_r <= (cmd.res == RES_STEP || cmd.res == RES_HIT);
      ost_r  <= (cmd.res == RES_FULL) ? ST_FULL :
                (cmd.res == RES_END)  ? ST_END  : ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r    <= '0;
      used_r    <= '0;
      ib_r      <= '0;
      iter_r    <= NIL;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.insert) begin
        bvld_r[bucket_r] <= 1'b1;
        used_r           <= used_r + NODE_W'(1);
      end
      if (cmd.iter_clr) begin
        ib_r   <= '0;
        iter_r <= NIL;
      end else if (cmd.ib_inc) begin
        ib_r <= ib_r + IB_W'(1);
      end
      if (cmd.iter_from_next) begin
        iter_r <= nn_q;
      end else if (cmd.iter_from_head) begin
        iter_r <= {1'b0, head_q};
      end else if (cmd.iter_nil) begin
        iter_r <= NIL;
      end
      if (cmd.push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.req       = req_r;
    stat.cur_nil   = (cur_r == NIL);
    stat.key_eq    = (nk_q == key_r);
    stat.nn_nil    = (nn_q == NIL);
    stat.pool_full = (used_r == NIL);
    stat.iter_nil  = (iter_r == NIL);
    stat.ib_end    = ib_r[IB_W-1];
    stat.ib_vld    = bvld_r[ib_r[BKT_W-1:0]];
    stat.out_free  = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {oval_r, okey_r};
  assign out_tuser  = {ost_r, ohit_r};

endmodule

/* rtl/core/chained_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// Chained hash table, 256 buckets, 512-node pool, 32-bit keys and values.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser
// in_      in   [31:0] key, [63:32] value  [1:0] req_type
// out_     out  [31:0] key, [63:32] value  [0] hit, [2:1] status
//
// put/get walk the bucket's chain node by node and stop early on a key match.
// step: reports the end when the iterator has ended, moves on inside a chain, and
// skips empty buckets when the chain runs out; restart skips empty buckets too.
// Bucket heads are cleared at reset through flop valid bits: no clearing pass.
// One request in flight; the next word is taken while a result waits in the
// output register, and a stalled result holds the sequencer before its push.
// ----------------------------------------------------------------------------
module chained_hash_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key, value
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_key, out_value
  output logic [2:0]  out_tuser   // hit, status
);
  import cht_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cht_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

`include "chained_hash_table_unit_macros.svh"

  `CHT_ASSERT_IMP(a_hit_done, out_tvalid && out_tuser[0], out_tuser[2:1] == ST_DONE, "hit status")
  `CHT_ASSERT_IMP(a_full_empty, out_tvalid && out_tuser[2:1] == ST_FULL, out_tdata == 64'd0 && !out_tuser[0], "full data")
  `CHT_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready, "word taken while busy")
  `CHT_ASSERT_IMP(a_push_free, cmd.push, stat.out_free, "push over pending word")

endmodule
